// ----- sv/aging_page_replacement_defines.svh -----
// assertion macros used by the checker file of the aging page replacement block
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define APR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define APR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/apr_pkg.sv -----
// shared constants, types and helpers of the aging page replacement block
// no dependencies
package apr_pkg;

  localparam int FRAMES    = 16;
  localparam int AGE_BITS  = 8;
  localparam int PAGE_BITS = 16;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int CFG_W  = 5;
  localparam int FIDX_W = 4;
  localparam int TOT_W  = 32;

  localparam logic [CFG_W-1:0]    ACTIVE_RST = CFG_W'(16);
  localparam logic [AGE_BITS-1:0] AGE_TOP    = {1'b1, {(AGE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } apr_state_e;

  // token that walks the row of frame cells
  typedef struct packed {
    logic                 vld;
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     used;
    logic                 found;
    logic [IDX_W-1:0]     where;
    logic [AGE_BITS-1:0]  lowest;
    logic [IDX_W-1:0]     vidx;
  } apr_tok_t;

  // victim fill broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [PAGE_BITS-1:0] page;
  } apr_wr_t;

  function automatic logic [CNT_W-1:0] frames_used(input logic [CFG_W-1:0] act);
    if (int'(act) > FRAMES) begin
      return CNT_W'(FRAMES);
    end
    return CNT_W'(act);
  endfunction

  function automatic logic [FIDX_W-1:0] to_fidx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+FIDX_W-1:0] w;
    w = {{FIDX_W{1'b0}}, idx};
    return w[FIDX_W-1:0];
  endfunction

endpackage

// ----- sv/apr_page_if.sv -----
// valid/ready channel carrying one page reference per beat
// depends on apr_pkg
interface apr_page_if import apr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

// ----- sv/apr_result_if.sv -----
// valid/ready channel carrying one replacement result per beat
// depends on apr_pkg
interface apr_result_if import apr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [FIDX_W-1:0] frame_index;
  logic [TOT_W-1:0]  hit_total;
  logic [TOT_W-1:0]  miss_total;

  modport source (output valid, output hit, output frame_index, output hit_total,
                  output miss_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input hit_total,
                  input miss_total, output ready);
endinterface

// ----- sv/apr_cell.sv -----
// one page frame: stored page, valid bit and age counter, plus one token stage
// depends on apr_pkg
module apr_cell import apr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  apr_tok_t         tok_i,
  input  apr_wr_t          wr_i,
  output apr_tok_t         tok_o
);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid_q, valid_d;
  logic [AGE_BITS-1:0]  age_q, age_d;
  logic [AGE_BITS-1:0]  aged;
  logic                 active, match, take;
  apr_tok_t             tok_q, tok_d;

  always_comb begin
    active  = tok_i.vld && (CNT_W'(cell_idx_i) < tok_i.used);
    aged    = age_q >> 1;
    match   = valid_q && (page_q == tok_i.page);
    // victim candidate: empty or strictly below the running minimum
    take    = (aged < tok_i.lowest) || !valid_q;
    tok_d   = tok_i;
    age_d   = age_q;
    valid_d = valid_q;
    page_d  = page_q;
    if (active) begin
      age_d = match ? (aged | AGE_TOP) : aged;
      if (match && !tok_i.found) begin
        tok_d.where = cell_idx_i;
      end
      if (match) begin
        tok_d.found = 1'b1;
      end
      if (take) begin
        tok_d.lowest = aged;
        tok_d.vidx   = cell_idx_i;
      end
    end
    if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      page_d  = wr_i.page;
      valid_d = 1'b1;
      age_d   = AGE_TOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign tok_o = tok_q;

endmodule

// ----- sv/aging_page_replacement.sv -----
// top level of the aging page replacement block: frame cell row, sequencer, totals
// depends on apr_pkg, apr_page_if, apr_result_if and apr_cell
//
// Each accepted page reference launches a token down a row of FRAMES frame cells,
// one cell per cycle; each active cell ages its counter, checks for the page and
// updates the running victim choice as the token passes. After the row, a fill of
// the victim frame (on a miss) and the totals update happen together in the commit cycle.
// A new reference is taken only once the previous one has walked the cell row and
// been committed, so one reference is in flight at a time. The result sits in
// an output register, so the commit of a finished item waits only if an earlier
// result has not been taken. active_frames is written through cfg_we_i/cfg_data_i
// and resets to 16; values above FRAMES act as FRAMES, zero forces every
// reference to miss into frame 0.
module aging_page_replacement import apr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  apr_page_if.sink         in_i,
  apr_result_if.source     out_o
);

  apr_state_e state_q, state_d;
  logic [CFG_W-1:0] active_q;
  apr_tok_t tok0_q, tok0_d;
  apr_tok_t tok [FRAMES+1];
  apr_tok_t fin_q;
  apr_wr_t  wr;
  logic     in_beat, commit;
  logic [TOT_W-1:0] hits_q, misses_q, hits_d, misses_d;
  logic              out_vld_q;
  logic              out_hit_q;
  logic [FIDX_W-1:0] out_fidx_q;

  assign in_beat = in_i.valid && in_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_beat) state_d = S_WALK;
      S_WALK: if (tok[FRAMES].vld) state_d = S_DONE;
      S_DONE: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      S_IDLE: in_i.ready = 1'b1;
      S_WALK: ;
      S_DONE: commit = !out_vld_q || out_o.ready;
      default: ;
    endcase
  end

  always_comb begin
    tok0_d        = '0;
    tok0_d.vld    = in_beat;
    tok0_d.page   = in_i.page_number;
    tok0_d.used   = frames_used(active_q);
    tok0_d.lowest = '1;
  end

  assign tok[0] = tok0_q;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    apr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(k)),
      .tok_i      (tok[k]),
      .wr_i       (wr),
      .tok_o      (tok[k+1])
    );
  end

  always_comb begin
    wr.en   = commit && !fin_q.found;
    wr.idx  = fin_q.vidx;
    wr.page = fin_q.page;
  end

  assign hits_d   = hits_q + TOT_W'(fin_q.found);
  assign misses_d = misses_q + TOT_W'(!fin_q.found);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= ACTIVE_RST;
      tok0_q    <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tok0_q  <= tok0_d;
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
      if (commit) begin
        hits_q    <= hits_d;
        misses_q  <= misses_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[FRAMES].vld) begin
      fin_q <= tok[FRAMES];
    end
    if (commit) begin
      out_hit_q  <= fin_q.found;
      out_fidx_q <= to_fidx(fin_q.found ? fin_q.where : fin_q.vidx);
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.frame_index = out_fidx_q;
  assign out_o.hit_total   = hits_q;
  assign out_o.miss_total  = misses_q;

endmodule

// ----- sv/apr_checker.sv -----
// port-level checks of aging_page_replacement, bound to the top level
// depends on apr_pkg and aging_page_replacement_defines.svh
`include "aging_page_replacement_defines.svh"

module apr_checker import apr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_hit,
  input logic [FIDX_W-1:0] out_fidx,
  input logic [TOT_W-1:0]  out_hits,
  input logic [TOT_W-1:0]  out_misses
);

  logic             out_beat;
  logic [TOT_W-1:0] last_hits_q, last_misses_q;
  logic [TOT_W-1:0] exp_hits, exp_misses;

  assign out_beat   = out_valid && out_ready;
  assign exp_hits   = last_hits_q + TOT_W'(out_hit);
  assign exp_misses = last_misses_q + TOT_W'(!out_hit);

  // totals seen at the previous result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hits_q   <= '0;
      last_misses_q <= '0;
    end else if (out_beat) begin
      last_hits_q   <= out_hits;
      last_misses_q <= out_misses;
    end
  end

  // a stalled result holds its payload
  `APR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_fidx) && $stable(out_hits) && $stable(out_misses))
  // each result moves exactly one total by one
  `APR_ASSERT_IMPL(a_totals_step, clk_i, rst_ni, out_valid, out_hits == exp_hits && out_misses == exp_misses)
  // one reference in flight at a time
  `APR_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  // a taken result is never offered again
  `APR_ASSERT_NEXT(a_out_fresh, clk_i, rst_ni, out_beat, !out_valid || !$stable(out_hits + out_misses))

endmodule

bind aging_page_replacement apr_checker u_apr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_hit    (out_o.hit),
  .out_fidx   (out_o.frame_index),
  .out_hits   (out_o.hit_total),
  .out_misses (out_o.miss_total)
);
